[hdl/dir_pkg.sv]
// ----------------------------------------------------------------------------
// dir_pkg: shared types and helpers for the depth interaction row.
// Holds the pipeline payload types and the per-step division arithmetic.
// ----------------------------------------------------------------------------
package dir_pkg;

    // Number of quotient bits that the divider produces (the result saturates above).
    localparam int QUO_W = 31;
    // Width of the numerator magnitude.
    localparam int MAG_W = 29;
    // Width of the partial remainder.
    localparam int REM_W = 17;
    // Number of divider stages, two quotient bits per stage (one in the last stage).
    localparam int DIV_STAGES = 16;

    // One input pixel as it enters the pipeline.
    typedef struct packed {
        logic [9:0]  row_index;
        logic [9:0]  col_index;
        logic [15:0] depth_center;
        logic [15:0] depth_left;
        logic [15:0] depth_right;
        logic [15:0] depth_above;
        logic [15:0] depth_below;
    } pix_t;

    // State of one quotient under division.
    typedef struct packed {
        logic              neg;
        logic              ovf;
        logic [MAG_W-1:0]  mag;
        logic [REM_W-1:0]  rem;
        logic [QUO_W-1:0]  quo;
    } lane_t;

    // Payload that travels through the divider stages.
    typedef struct packed {
        logic signed [39:0] rot_x;
        logic signed [39:0] rot_y;
        logic signed [27:0] rot_z;
        logic [15:0]        depth;
        logic               zero;
        lane_t [2:0]        lane;
    } work_t;

    // Finished result beat.
    typedef struct packed {
        logic signed [31:0] grad_x_over_depth;
        logic signed [31:0] grad_y_over_depth;
        logic signed [31:0] depth_term_over_depth;
        logic signed [39:0] rot_x_term;
        logic signed [39:0] rot_y_term;
        logic signed [27:0] rot_z_term;
        logic               zero_depth;
    } res_t;

    // Result of one restoring division step.
    typedef struct packed {
        logic             q;
        logic [REM_W-1:0] rem;
    } step_t;

    // Set up a lane: sign, magnitude, overflow check and first remainder.
    function automatic lane_t lane_prep(input logic signed [29:0] num, input logic [15:0] z);
        lane_t l;
        logic signed [29:0] absv;
        absv = num[29] ? -num : num;
        l.neg = num[29];
        l.mag = absv[MAG_W-1:0];
        // The quotient reaches 2^31 exactly when the magnitude reaches z * 2^15.
        l.ovf = {3'b000, absv[MAG_W-1:0]} >= {1'b0, z, 15'b0};
        l.rem = REM_W'(absv[MAG_W-1:15]);
        l.quo = '0;
        return l;
    endfunction

    // One restoring division step: shift in a dividend bit, subtract if it fits.
    function automatic step_t div_step(input logic [REM_W-1:0] rem, input logic [15:0] z,
                                       input logic b);
        step_t s;
        logic [REM_W:0] t;
        t = {rem, b};
        if (t >= {2'b00, z})
        begin
            s.q   = 1'b1;
            s.rem = REM_W'(t - {2'b00, z});
        end
        else
        begin
            s.q   = 1'b0;
            s.rem = t[REM_W-1:0];
        end
        return s;
    endfunction

    // Apply sign, saturation and the zero-depth rule to a finished lane.
    function automatic logic signed [31:0] lane_finish(input lane_t l, input logic zero);
        logic signed [31:0] r;
        if (zero)
            r = '0;
        else if (l.ovf)
            r = l.neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
        else if (l.neg)
            r = -$signed({1'b0, l.quo});
        else
            r = $signed({1'b0, l.quo});
        return r;
    endfunction

endpackage

[hdl/dir_pix_if.sv]
// ----------------------------------------------------------------------------
// dir_pix_if: pixel input channel.
// Carries one depth pixel with its coordinates and four neighbors per beat.
// ----------------------------------------------------------------------------
interface dir_pix_if;
    logic        valid;
    logic        ready;
    logic [9:0]  row_index;
    logic [9:0]  col_index;
    logic [15:0] depth_center;
    logic [15:0] depth_left;
    logic [15:0] depth_right;
    logic [15:0] depth_above;
    logic [15:0] depth_below;

    modport source (output valid, row_index, col_index, depth_center, depth_left,
                    depth_right, depth_above, depth_below, input ready);
    modport sink (input valid, row_index, col_index, depth_center, depth_left,
                  depth_right, depth_above, depth_below, output ready);
endinterface

[hdl/dir_res_if.sv]
// ----------------------------------------------------------------------------
// dir_res_if: interaction row result channel.
// Carries the six interaction terms and the zero-depth flag per beat.
// ----------------------------------------------------------------------------
interface dir_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] grad_x_over_depth;
    logic signed [31:0] grad_y_over_depth;
    logic signed [31:0] depth_term_over_depth;
    logic signed [39:0] rot_x_term;
    logic signed [39:0] rot_y_term;
    logic signed [27:0] rot_z_term;
    logic               zero_depth;

    modport source (output valid, grad_x_over_depth, grad_y_over_depth,
                    depth_term_over_depth, rot_x_term, rot_y_term, rot_z_term,
                    zero_depth, input ready);
    modport sink (input valid, grad_x_over_depth, grad_y_over_depth,
                  depth_term_over_depth, rot_x_term, rot_y_term, rot_z_term,
                  zero_depth, output ready);
endinterface

[hdl/dir_front.sv]
// ----------------------------------------------------------------------------
// dir_front: gradient and product stages.
// Four register stages form the gradients, the products and the rotation
// terms, and prepare the three quotient lanes for the divider.
// ----------------------------------------------------------------------------
module dir_front #(
    parameter int MAX_COORD = 1023
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  dir_pkg::pix_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output dir_pkg::work_t out_data
);

    // Stage 1 registers: clamped coordinates and gradients.
    logic               v1_reg;
    logic [9:0]         i1_reg, j1_reg;
    logic [15:0]        z1_reg;
    logic signed [16:0] a1_reg, b1_reg;

    // Stage 2 registers: first products.
    logic               v2_reg;
    logic [15:0]        z2_reg;
    logic signed [16:0] a2_reg, b2_reg;
    logic signed [27:0] ia2_reg, jb2_reg, ib2_reg, ja2_reg;
    logic [19:0]        ij2_reg, ii2_reg, jj2_reg;
    logic [25:0]        iz2_reg, jz2_reg;

    // Stage 3 registers: second products and partial sums.
    logic               v3_reg;
    logic [15:0]        z3_reg;
    logic signed [16:0] a3_reg, b3_reg;
    logic signed [37:0] ija3_reg, ijb3_reg, jjb3_reg, iia3_reg;
    logic signed [29:0] nd3_reg;
    logic signed [27:0] rz3_reg;
    logic [25:0]        iz3_reg, jz3_reg;

    // Stage 4 register: divider payload.
    logic               v4_reg;
    dir_pkg::work_t     w4_reg;

    logic r1, r2, r3, r4;
    logic [9:0] i_clamp, j_clamp;
    dir_pkg::work_t w4_next;

    // Stall chain: a stage takes new data when empty or when it moves on.
    assign r4       = !v4_reg || out_ready;
    assign r3       = !v3_reg || r4;
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign in_ready = r1;

    // Coordinates above the limit saturate to it.
    always_comb
    begin
        i_clamp = ({2'b00, in_data.row_index} > 12'(MAX_COORD)) ?
                  10'(MAX_COORD) : in_data.row_index;
        j_clamp = ({2'b00, in_data.col_index} > 12'(MAX_COORD)) ?
                  10'(MAX_COORD) : in_data.col_index;
    end

    // Stage 1: gradients.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (r1)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (r1)
        begin
            i1_reg <= i_clamp;
            j1_reg <= j_clamp;
            z1_reg <= in_data.depth_center;
            a1_reg <= $signed({1'b0, in_data.depth_right}) - $signed({1'b0, in_data.depth_left});
            b1_reg <= $signed({1'b0, in_data.depth_below}) - $signed({1'b0, in_data.depth_above});
        end
    end

    // Stage 2: coordinate products.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (r2)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (r2)
        begin
            z2_reg  <= z1_reg;
            a2_reg  <= a1_reg;
            b2_reg  <= b1_reg;
            ia2_reg <= $signed({1'b0, i1_reg}) * a1_reg;
            jb2_reg <= $signed({1'b0, j1_reg}) * b1_reg;
            ib2_reg <= $signed({1'b0, i1_reg}) * b1_reg;
            ja2_reg <= $signed({1'b0, j1_reg}) * a1_reg;
            ij2_reg <= i1_reg * j1_reg;
            ii2_reg <= i1_reg * i1_reg;
            jj2_reg <= j1_reg * j1_reg;
            iz2_reg <= i1_reg * z1_reg;
            jz2_reg <= j1_reg * z1_reg;
        end
    end

    // Stage 3: second-order products, depth numerator and the z rotation.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (r3)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (r3)
        begin
            z3_reg   <= z2_reg;
            a3_reg   <= a2_reg;
            b3_reg   <= b2_reg;
            ija3_reg <= $signed({1'b0, ij2_reg}) * a2_reg;
            ijb3_reg <= $signed({1'b0, ij2_reg}) * b2_reg;
            jjb3_reg <= $signed({1'b0, jj2_reg}) * b2_reg;
            iia3_reg <= $signed({1'b0, ii2_reg}) * a2_reg;
            nd3_reg  <= -(30'($signed({1'b0, z2_reg})) + 30'(ia2_reg) + 30'(jb2_reg));
            rz3_reg  <= ib2_reg - ja2_reg;
            iz3_reg  <= iz2_reg;
            jz3_reg  <= jz2_reg;
        end
    end

    // Stage 4: rotation sums and divider lane setup.
    always_comb
    begin
        w4_next.rot_x = -40'($signed({1'b0, jz3_reg})) - 40'(ija3_reg)
                        - 40'(b3_reg) - 40'(jjb3_reg);
        w4_next.rot_y = 40'($signed({1'b0, iz3_reg})) + 40'(ijb3_reg)
                        + 40'(a3_reg) + 40'(iia3_reg);
        w4_next.rot_z = rz3_reg;
        w4_next.depth = z3_reg;
        w4_next.zero  = (z3_reg == 16'd0);
        w4_next.lane[0] = dir_pkg::lane_prep(30'(a3_reg), z3_reg);
        w4_next.lane[1] = dir_pkg::lane_prep(30'(b3_reg), z3_reg);
        w4_next.lane[2] = dir_pkg::lane_prep(nd3_reg, z3_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (r4)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (r4)
            w4_reg <= w4_next;
    end

    assign out_valid = v4_reg;
    assign out_data  = w4_reg;

endmodule

[hdl/dir_div_pipe.sv]
// ----------------------------------------------------------------------------
// dir_div_pipe: pipelined restoring divider for the three quotients.
// Each stage resolves two quotient bits per lane (the last stage one); a final
// register applies sign, saturation and the zero-depth rule.
// ----------------------------------------------------------------------------
module dir_div_pipe (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  dir_pkg::work_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output dir_pkg::res_t  out_data
);

    localparam int N = dir_pkg::DIV_STAGES;

    logic           v_reg [N];
    dir_pkg::work_t d_reg [N];
    dir_pkg::work_t src   [N];
    dir_pkg::work_t nxt   [N];
    logic           vsrc  [N];
    logic           rdy   [N+1];

    logic           res_valid_reg;
    dir_pkg::res_t  res_reg;
    dir_pkg::res_t  res_next;

    // Output register is free when empty or when its beat is taken.
    assign rdy[N]   = !res_valid_reg || out_ready;
    assign in_ready = rdy[0];

    genvar s, l;
    generate
        for (s = 0; s < N; s++)
        begin : g_stage
            localparam int K1 = dir_pkg::QUO_W - 1 - 2 * s;
            localparam int K0 = K1 - 1;

            assign rdy[s] = !v_reg[s] || rdy[s+1];

            if (s == 0)
            begin : g_first
                assign src[s]  = in_data;
                assign vsrc[s] = in_valid;
            end
            else
            begin : g_next
                assign src[s]  = d_reg[s-1];
                assign vsrc[s] = v_reg[s-1];
            end

            // Two dependent division steps per lane; the last stage keeps only the first.
            for (l = 0; l < 3; l++)
            begin : g_lane
                logic          b1, b0;
                dir_pkg::step_t st1, st0;
                dir_pkg::lane_t ln;

                if (K1 >= 16)
                begin : g_b1
                    assign b1 = src[s].lane[l].mag[K1-16];
                end
                else
                begin : g_b1z
                    assign b1 = 1'b0;
                end

                if (K0 >= 16)
                begin : g_b0
                    assign b0 = src[s].lane[l].mag[K0-16];
                end
                else
                begin : g_b0z
                    assign b0 = 1'b0;
                end

                assign st1 = dir_pkg::div_step(src[s].lane[l].rem, src[s].depth, b1);
                assign st0 = dir_pkg::div_step(st1.rem, src[s].depth, b0);

                always_comb
                begin
                    ln         = src[s].lane[l];
                    ln.quo[K1] = st1.q;
                    ln.rem     = st1.rem;
                    if (K0 >= 0)
                    begin
                        ln.quo[(K0 >= 0) ? K0 : 0] = st0.q;
                        ln.rem                     = st0.rem;
                    end
                end

                assign nxt[s].lane[l] = ln;
            end

            assign nxt[s].rot_x = src[s].rot_x;
            assign nxt[s].rot_y = src[s].rot_y;
            assign nxt[s].rot_z = src[s].rot_z;
            assign nxt[s].depth = src[s].depth;
            assign nxt[s].zero  = src[s].zero;

            // Valid bit travels with the stage data.
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[s] <= 1'b0;
                else if (rdy[s])
                    v_reg[s] <= vsrc[s];
            end

            always_ff @(posedge clk)
            begin
                if (rdy[s])
                    d_reg[s] <= nxt[s];
            end
        end
    endgenerate

    // Final stage: signs, saturation and the zero-depth rule.
    always_comb
    begin
        res_next.grad_x_over_depth     = dir_pkg::lane_finish(d_reg[N-1].lane[0], d_reg[N-1].zero);
        res_next.grad_y_over_depth     = dir_pkg::lane_finish(d_reg[N-1].lane[1], d_reg[N-1].zero);
        res_next.depth_term_over_depth = dir_pkg::lane_finish(d_reg[N-1].lane[2], d_reg[N-1].zero);
        res_next.rot_x_term            = d_reg[N-1].rot_x;
        res_next.rot_y_term            = d_reg[N-1].rot_y;
        res_next.rot_z_term            = d_reg[N-1].rot_z;
        res_next.zero_depth            = d_reg[N-1].zero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (rdy[N])
            res_valid_reg <= v_reg[N-1];
    end

    always_ff @(posedge clk)
    begin
        if (rdy[N])
            res_reg <= res_next;
    end

    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

endmodule

[hdl/depth_interaction_row.sv]
// Throughput: one pixel per cycle while the result side is ready; the front
// stages, the 16 divider stages, two quotient bits each (one in the last), and
// the output register set the depth, and every stage holds its own beat under stall.
// Reset: rst_n clears all stage valid bits asynchronously; payload is not reset.
// ----------------------------------------------------------------------------
// depth_interaction_row: one row of the dense depth interaction matrix.
// Forms the depth gradients, the three depth-normalized terms and the three
// rotation terms for each incoming depth pixel.
// ----------------------------------------------------------------------------
module depth_interaction_row #(
    parameter int MAX_COORD = 1023
) (
    input logic        clk,
    input logic        rst_n,
    dir_pix_if.sink    pix,
    dir_res_if.source  res
);

    dir_pkg::pix_t  pix_data;
    dir_pkg::work_t work_data;
    dir_pkg::res_t  res_data;
    logic           work_valid;
    logic           work_ready;

    // Pack the pixel beat.
    always_comb
    begin
        pix_data.row_index    = pix.row_index;
        pix_data.col_index    = pix.col_index;
        pix_data.depth_center = pix.depth_center;
        pix_data.depth_left   = pix.depth_left;
        pix_data.depth_right  = pix.depth_right;
        pix_data.depth_above  = pix.depth_above;
        pix_data.depth_below  = pix.depth_below;
    end

    dir_front #(
        .MAX_COORD (MAX_COORD)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pix.valid),
        .in_ready  (pix.ready),
        .in_data   (pix_data),
        .out_valid (work_valid),
        .out_ready (work_ready),
        .out_data  (work_data)
    );

    dir_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (work_valid),
        .in_ready  (work_ready),
        .in_data   (work_data),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .out_data  (res_data)
    );

    // Unpack the result beat.
    assign res.grad_x_over_depth     = res_data.grad_x_over_depth;
    assign res.grad_y_over_depth     = res_data.grad_y_over_depth;
    assign res.depth_term_over_depth = res_data.depth_term_over_depth;
    assign res.rot_x_term            = res_data.rot_x_term;
    assign res.rot_y_term            = res_data.rot_y_term;
    assign res.rot_z_term            = res_data.rot_z_term;
    assign res.zero_depth            = res_data.zero_depth;

    // A zero depth beat carries zero quotients.
    a_zero_quot: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.zero_depth |->
            res.grad_x_over_depth == 32'sd0 && res.grad_y_over_depth == 32'sd0 &&
            res.depth_term_over_depth == 32'sd0)
        else $error("zero depth result with nonzero quotient");

    // The pipeline only refuses a pixel when a result is waiting and stalled.
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !pix.ready |-> res.valid && !res.ready)
        else $error("pixel refused without output back-pressure");

    // A stalled result beat holds its payload until it is taken.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.ready |=> res.valid && $stable(res_data))
        else $error("result beat changed while stalled");

endmodule

[tb/dir_row_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dir_row_checker: result checker for the depth interaction row.
// Watches the pixel and result channels, computes the expected interaction
// row for every accepted pixel beat and compares each result beat with it.
// ----------------------------------------------------------------------------
module dir_row_checker #(
    parameter int MAX_COORD = 1023
) (
    input  logic  clk,
    input  logic  rst_n,
    dir_pix_if    pix,
    dir_res_if    res,
    output int    fail_count,
    output int    rows_pending
);

    dir_pkg::res_t row_queue[$];

    // Quotient in Q16.16, truncated toward zero, then saturated.
    function automatic logic signed [31:0] q16_div(input longint num, input longint z);
        longint q;
        q = (num * 65536) / z;
        if (q > 64'sd2147483647)
            q = 64'sd2147483647;
        else if (q < -64'sd2147483648)
            q = -64'sd2147483648;
        return q[31:0];
    endfunction

    function automatic longint sat_val(input longint v, input longint lim);
        if (v > lim)
            return lim;
        if (v < -lim - 1)
            return -lim - 1;
        return v;
    endfunction

    // Expected interaction row for one pixel beat.
    function automatic dir_pkg::res_t interaction_row(input dir_pkg::pix_t p);
        dir_pkg::res_t r;
        longint i, j, z, a, b, rx, ry, rz;
        i = (p.row_index > MAX_COORD) ? MAX_COORD : p.row_index;
        j = (p.col_index > MAX_COORD) ? MAX_COORD : p.col_index;
        z = p.depth_center;
        a = longint'(p.depth_right) - longint'(p.depth_left);
        b = longint'(p.depth_below) - longint'(p.depth_above);
        r.zero_depth = (z == 0);
        if (z == 0)
        begin
            r.grad_x_over_depth     = '0;
            r.grad_y_over_depth     = '0;
            r.depth_term_over_depth = '0;
        end
        else
        begin
            r.grad_x_over_depth     = q16_div(a, z);
            r.grad_y_over_depth     = q16_div(b, z);
            r.depth_term_over_depth = q16_div(-(z + i * a + j * b), z);
        end
        rx = sat_val(-(j * z) - i * j * a - (1 + j * j) * b, 64'sd549755813887);
        ry = sat_val(i * z + i * j * b + (1 + i * i) * a, 64'sd549755813887);
        rz = sat_val(i * b - j * a, 64'sd134217727);
        r.rot_x_term = rx[39:0];
        r.rot_y_term = ry[39:0];
        r.rot_z_term = rz[27:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
        fail_count++;
    endtask

    initial
    begin
        fail_count   = 0;
        rows_pending = 0;
    end

    always @(posedge clk)
    begin
        dir_pkg::pix_t p;
        dir_pkg::res_t want;
        if (rst_n && pix.valid && pix.ready)
        begin
            p = '{pix.row_index, pix.col_index, pix.depth_center, pix.depth_left,
                  pix.depth_right, pix.depth_above, pix.depth_below};
            row_queue = {row_queue, interaction_row(p)};
        end
        if (rst_n && res.valid && res.ready)
        begin
            if (row_queue.size() == 0)
                report_mismatch("unexpected result beat", 0, 0);
            else
            begin
                want = row_queue.pop_front();
                if (res.grad_x_over_depth !== want.grad_x_over_depth)
                    report_mismatch("grad_x_over_depth", res.grad_x_over_depth,
                                    want.grad_x_over_depth);
                if (res.grad_y_over_depth !== want.grad_y_over_depth)
                    report_mismatch("grad_y_over_depth", res.grad_y_over_depth,
                                    want.grad_y_over_depth);
                if (res.depth_term_over_depth !== want.depth_term_over_depth)
                    report_mismatch("depth_term_over_depth", res.depth_term_over_depth,
                                    want.depth_term_over_depth);
                if (res.rot_x_term !== want.rot_x_term)
                    report_mismatch("rot_x_term", res.rot_x_term, want.rot_x_term);
                if (res.rot_y_term !== want.rot_y_term)
                    report_mismatch("rot_y_term", res.rot_y_term, want.rot_y_term);
                if (res.rot_z_term !== want.rot_z_term)
                    report_mismatch("rot_z_term", res.rot_z_term, want.rot_z_term);
                if (res.zero_depth !== want.zero_depth)
                    report_mismatch("zero_depth", res.zero_depth, want.zero_depth);
            end
        end
        rows_pending = row_queue.size();
    end
endmodule

[tb/tb_depth_interaction_row.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_depth_interaction_row: testbench for the depth interaction row.
// Drives directed corner pixels and then random pixels with random gaps and
// result-side stalls; a checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_depth_interaction_row;

    localparam int RANDOM_PIXELS = 1300;
    localparam int DRAIN_CYCLES  = 40;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   rows_pending;

    dir_pix_if pix ();
    dir_res_if res ();

    depth_interaction_row dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix),
        .res   (res)
    );

    dir_row_checker checker_inst (
        .clk          (clk),
        .rst_n        (rst_n),
        .pix          (pix),
        .res          (res),
        .fail_count   (fail_count),
        .rows_pending (rows_pending)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Gap length: mostly zero or short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Random depth, biased toward the edges of the range.
    function automatic logic [15:0] rand_depth();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(1, 16));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [9:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 10'd0;
            1: return 10'd1023;
            default: return 10'($urandom);
        endcase
    endfunction

    // Result-side stalls in bursts; some stretches without stalls.
    initial
    begin
        int hold;
        res.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            res.ready = 1'b1;
            repeat ($urandom_range(1, 40)) @(negedge clk);
            hold = gap_len();
            if (hold > 0)
            begin
                res.ready = 1'b0;
                repeat (hold) @(negedge clk);
            end
        end
    end

    // Send one pixel beat, holding it until it is taken.
    task automatic send_pixel(input dir_pkg::pix_t p);
        pix.valid        = 1'b1;
        pix.row_index    = p.row_index;
        pix.col_index    = p.col_index;
        pix.depth_center = p.depth_center;
        pix.depth_left   = p.depth_left;
        pix.depth_right  = p.depth_right;
        pix.depth_above  = p.depth_above;
        pix.depth_below  = p.depth_below;
        do
            @(posedge clk);
        while (!pix.ready);
        @(negedge clk);
        pix.valid = 1'b0;
        repeat (gap_len()) @(negedge clk);
    endtask

    // Stimulus and verdict.
    initial
    begin
        dir_pkg::pix_t p;
        pix.valid = 1'b0;
        pix.row_index = '0;
        pix.col_index = '0;
        pix.depth_center = '0;
        pix.depth_left = '0;
        pix.depth_right = '0;
        pix.depth_above = '0;
        pix.depth_below = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed corners: zero depth, extreme gradients, extreme coordinates.
        send_pixel('{10'd0, 10'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0});
        send_pixel('{10'd1023, 10'd1023, 16'd0, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000});
        send_pixel('{10'd1023, 10'd1023, 16'd1, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF});
        send_pixel('{10'd1023, 10'd1023, 16'd1, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000});
        send_pixel('{10'd0, 10'd1023, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000});
        send_pixel('{10'd1023, 10'd0, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF});
        send_pixel('{10'd0, 10'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        send_pixel('{10'd512, 10'd256, 16'h0100, 16'h0100, 16'h0100, 16'h0100, 16'h0100});
        send_pixel('{10'd1, 10'd1, 16'd2, 16'd0, 16'd1, 16'd0, 16'd1});
        send_pixel('{10'd1, 10'd1, 16'd2, 16'd1, 16'd0, 16'd1, 16'd0});
        send_pixel('{10'd341, 10'd682, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555});
        send_pixel('{10'd682, 10'd341, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA});
        send_pixel('{10'd100, 10'd900, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF});

        // Let the pipeline empty once with the sender held off.
        while (rows_pending != 0)
            @(negedge clk);

        // Random pixels, each followed by a random gap.
        for (int n = 0; n < RANDOM_PIXELS; n++)
        begin
            p.row_index    = rand_coord();
            p.col_index    = rand_coord();
            p.depth_center = rand_depth();
            p.depth_left   = rand_depth();
            p.depth_right  = rand_depth();
            p.depth_above  = rand_depth();
            p.depth_below  = rand_depth();
            send_pixel(p);
        end

        while (rows_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("depth_interaction_row test passed");
        else
            $display("depth_interaction_row test failed");
        $finish;
    end

    // Timeout.
    initial
    begin
        #4000000;
        $display("depth_interaction_row test failed");
        $finish;
    end
endmodule
